[rtl/core/vprs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vprs_pkg
// Shared types, widths and register codes for the vertex projection and
// rectangle select pipeline.
// ----------------------------------------------------------------------------
package vprs_pkg;

  localparam int HW_W    = 34;  // homogeneous row sum, signed
  localparam int DEN_W   = 33;  // magnitude of a row sum
  localparam int REM_W   = 35;  // divider partial remainder
  localparam int QB      = 15;  // quotient bits below saturation
  localparam int PRD_W   = 52;  // edge cross products
  localparam int FRONT   = 5;   // stages ahead of the divider
  localparam int LATENCY = FRONT + QB + 1;

  typedef enum logic [2:0] {
    REG_ROW_ZERO   = 3'd0,
    REG_ROW_ONE    = 3'd1,
    REG_ROW_TWO    = 3'd2,
    REG_ROW_THREE  = 3'd3,
    REG_BOX_LEFT   = 3'd4,
    REG_BOX_BOTTOM = 3'd5,
    REG_BOX_WIDTH  = 3'd6,
    REG_BOX_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        result_index;
    logic               selected;
    logic signed [15:0] proj_x;
    logic signed [15:0] proj_y;
    logic               w_zero;
    logic               result_last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] index;
    logic        last;
  } meta_t;

  typedef struct packed {
    meta_t                  meta;
    logic signed [HW_W-1:0] hx;
    logic signed [HW_W-1:0] hy;
    logic signed [HW_W-1:0] hw;
  } xf_res_t;

  typedef struct packed {
    meta_t meta;
    logic  wz;
    logic  sel;
    logic  negx;
    logic  negy;
    logic  satx;
    logic  saty;
  } div_tag_t;

  function automatic logic signed [15:0] coef(input logic [63:0] row, input int c);
    coef = row[16*c +: 16];
  endfunction

endpackage

[rtl/core/vprs_xform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vprs_xform
// Two-stage matrix transform: coefficient products, then row sums for x, y, w.
// ----------------------------------------------------------------------------
module vprs_xform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  vprs_pkg::in_item_t in_item,
  input  logic [63:0]        row_x,
  input  logic [63:0]        row_y,
  input  logic [63:0]        row_w,
  output logic               out_v,
  output vprs_pkg::xf_res_t  out_res
);
  import vprs_pkg::*;

  logic [63:0]        rows [3];
  logic signed [15:0] crd  [3];
  logic signed [31:0] prod_r [3][3];
  meta_t              meta_r;
  logic               v1_r;
  logic               v2_r;
  xf_res_t            res_r;
  logic signed [HW_W-1:0] sum_nxt [3];

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_w;
  assign crd[0]  = in_item.coord_x;
  assign crd[1]  = in_item.coord_y;
  assign crd[2]  = in_item.coord_z;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= coef(rows[r], c) * crd[c];
      end
    end
    meta_r.index <= in_item.vertex_index;
    meta_r.last  <= in_item.last_vertex;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = HW_W'(prod_r[r][0]) + HW_W'(prod_r[r][1]) + HW_W'(prod_r[r][2])
                 + (HW_W'(coef(rows[r], 3)) <<< 8);
    end
  end

  always_ff @(posedge clk) begin
    res_r.meta <= meta_r;
    res_r.hx   <= sum_nxt[0];
    res_r.hy   <= sum_nxt[1];
    res_r.hw   <= sum_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  assign out_v   = v2_r;
  assign out_res = res_r;

endmodule

[rtl/core/vprs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vprs_div
// Pipelined restoring divider, one quotient bit per stage, for x and y
// against a shared denominator.
// ----------------------------------------------------------------------------
module vprs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  vprs_pkg::div_tag_t          in_tag,
  input  logic [vprs_pkg::DEN_W-1:0]  in_magx,
  input  logic [vprs_pkg::DEN_W-1:0]  in_magy,
  input  logic [vprs_pkg::DEN_W-1:0]  in_den,
  output logic                        out_v,
  output vprs_pkg::div_tag_t          out_tag,
  output logic [vprs_pkg::QB-1:0]     out_qx,
  output logic [vprs_pkg::QB-1:0]     out_qy
);
  import vprs_pkg::*;

  logic             v_r   [QB];
  div_tag_t         tag_r [QB];
  logic [DEN_W-1:0] den_r [QB];
  logic [REM_W-1:0] rx_r  [QB];
  logic [REM_W-1:0] ry_r  [QB];
  logic [QB-1:0]    qx_r  [QB];
  logic [QB-1:0]    qy_r  [QB];

  logic             v_s   [QB];
  div_tag_t         tag_s [QB];
  logic [DEN_W-1:0] den_s [QB];
  logic [REM_W-1:0] rx_s  [QB];
  logic [REM_W-1:0] ry_s  [QB];
  logic [QB-1:0]    qx_s  [QB];
  logic [QB-1:0]    qy_s  [QB];

  assign v_s[0]   = in_v;
  assign tag_s[0] = in_tag;
  assign den_s[0] = in_den;
  assign rx_s[0]  = REM_W'(in_magx);
  assign ry_s[0]  = REM_W'(in_magy);
  assign qx_s[0]  = '0;
  assign qy_s[0]  = '0;

  for (genvar s = 1; s < QB; s++) begin : g_link
    assign v_s[s]   = v_r[s-1];
    assign tag_s[s] = tag_r[s-1];
    assign den_s[s] = den_r[s-1];
    assign rx_s[s]  = rx_r[s-1];
    assign ry_s[s]  = ry_r[s-1];
    assign qx_s[s]  = qx_r[s-1];
    assign qy_s[s]  = qy_r[s-1];
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic             bx;
    logic             by;
    logic [REM_W-1:0] dx;
    logic [REM_W-1:0] dy;

    assign bx = rx_s[s] >= REM_W'(den_s[s]);
    assign by = ry_s[s] >= REM_W'(den_s[s]);
    assign dx = rx_s[s] - (bx ? REM_W'(den_s[s]) : '0);
    assign dy = ry_s[s] - (by ? REM_W'(den_s[s]) : '0);

    always_ff @(posedge clk) begin
      tag_r[s] <= tag_s[s];
      den_r[s] <= den_s[s];
      rx_r[s]  <= dx << 1;
      ry_r[s]  <= dy << 1;
      qx_r[s]  <= {qx_s[s][QB-2:0], bx};
      qy_r[s]  <= {qy_s[s][QB-2:0], by};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_s[s];
      end
    end
  end

  assign out_v   = v_r[QB-1];
  assign out_tag = tag_r[QB-1];
  assign out_qx  = qx_r[QB-1];
  assign out_qy  = qy_r[QB-1];

endmodule

[rtl/core/vertex_project_rect_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_rect_select
// Vertex transform, perspective divide and strict rectangle hit test.
// ----------------------------------------------------------------------------
// Pipeline from start to out_valid: 2 transform stages, 3 sign, magnitude and
//   edge-product stages, 15 divider stages, 1 output register.
// Throughput: one vertex per cycle; the bit-per-stage divider sets the depth.
// busy is always low; results appear one cycle each on out_valid.
// Reset clears all valid bits and all configuration registers to zero.
module vertex_project_rect_select (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vprs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output vprs_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import vprs_pkg::*;

  logic [63:0]        row_r [4];
  logic [15:0]        box_left_r;
  logic [15:0]        box_bottom_r;
  logic [15:0]        box_width_r;
  logic [15:0]        box_height_r;
  logic signed [16:0] left_s;
  logic signed [16:0] bottom_s;
  logic signed [16:0] right_r;
  logic signed [16:0] top_r;
  reg_idx_t           widx;
  logic               wr_en;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        row_r[i] <= '0;
      end
      box_left_r   <= '0;
      box_bottom_r <= '0;
      box_width_r  <= '0;
      box_height_r <= '0;
    end else if (wr_en) begin
      unique case (widx)
        REG_ROW_ZERO:   row_r[0]     <= pwdata;
        REG_ROW_ONE:    row_r[1]     <= pwdata;
        REG_ROW_TWO:    row_r[2]     <= pwdata;
        REG_ROW_THREE:  row_r[3]     <= pwdata;
        REG_BOX_LEFT:   box_left_r   <= pwdata[15:0];
        REG_BOX_BOTTOM: box_bottom_r <= pwdata[15:0];
        REG_BOX_WIDTH:  box_width_r  <= pwdata[15:0];
        REG_BOX_HEIGHT: box_height_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ROW_ZERO:   prdata = row_r[0];
      REG_ROW_ONE:    prdata = row_r[1];
      REG_ROW_TWO:    prdata = row_r[2];
      REG_ROW_THREE:  prdata = row_r[3];
      REG_BOX_LEFT:   prdata = {48'd0, box_left_r};
      REG_BOX_BOTTOM: prdata = {48'd0, box_bottom_r};
      REG_BOX_WIDTH:  prdata = {48'd0, box_width_r};
      REG_BOX_HEIGHT: prdata = {48'd0, box_height_r};
      default:        prdata = '0;
    endcase
  end

  assign left_s   = {box_left_r[15], box_left_r};
  assign bottom_s = {box_bottom_r[15], box_bottom_r};

  always_ff @(posedge clk) begin
    right_r <= left_s + {box_width_r[15], box_width_r};
    top_r   <= bottom_s + {box_height_r[15], box_height_r};
  end

  // transform
  logic    xf_v;
  xf_res_t xf_res;

  vprs_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (start && !busy),
    .in_item (in_data),
    .row_x   (row_r[0]),
    .row_y   (row_r[1]),
    .row_w   (row_r[3]),
    .out_v   (xf_v),
    .out_res (xf_res)
  );

  // stage 3: make w positive
  logic                   v3_r;
  meta_t                  meta3_r;
  logic                   wz3_r;
  logic signed [HW_W-1:0] hx3_r;
  logic signed [HW_W-1:0] hy3_r;
  logic signed [HW_W-1:0] hw3_r;

  always_ff @(posedge clk) begin
    meta3_r <= xf_res.meta;
    wz3_r   <= (xf_res.hw == '0);
    hx3_r   <= xf_res.hw[HW_W-1] ? -xf_res.hx : xf_res.hx;
    hy3_r   <= xf_res.hw[HW_W-1] ? -xf_res.hy : xf_res.hy;
    hw3_r   <= xf_res.hw[HW_W-1] ? -xf_res.hw : xf_res.hw;
  end

  // stage 4: magnitudes, saturation, edge products
  logic                    v4_r;
  meta_t                   meta4_r;
  logic                    wz4_r;
  logic [DEN_W-1:0]        magx_nxt;
  logic [DEN_W-1:0]        magy_nxt;
  logic [DEN_W-1:0]        den_nxt;
  logic [DEN_W-1:0]        magx4_r;
  logic [DEN_W-1:0]        magy4_r;
  logic [DEN_W-1:0]        den4_r;
  logic                    negx4_r;
  logic                    negy4_r;
  logic                    satx4_r;
  logic                    saty4_r;
  logic signed [PRD_W-1:0] hw_e;
  logic signed [PRD_W-1:0] sx4_r;
  logic signed [PRD_W-1:0] sy4_r;
  logic signed [PRD_W-1:0] lh4_r;
  logic signed [PRD_W-1:0] rh4_r;
  logic signed [PRD_W-1:0] bh4_r;
  logic signed [PRD_W-1:0] th4_r;

  assign magx_nxt = DEN_W'(hx3_r[HW_W-1] ? -hx3_r : hx3_r);
  assign magy_nxt = DEN_W'(hy3_r[HW_W-1] ? -hy3_r : hy3_r);
  assign den_nxt  = DEN_W'(hw3_r);
  assign hw_e     = PRD_W'(hw3_r);

  always_ff @(posedge clk) begin
    meta4_r <= meta3_r;
    wz4_r   <= wz3_r;
    magx4_r <= magx_nxt;
    magy4_r <= magy_nxt;
    den4_r  <= den_nxt;
    negx4_r <= hx3_r[HW_W-1];
    negy4_r <= hy3_r[HW_W-1];
    satx4_r <= {1'b0, magx_nxt} >= {den_nxt, 1'b0};
    saty4_r <= {1'b0, magy_nxt} >= {den_nxt, 1'b0};
    sx4_r   <= PRD_W'(hx3_r) <<< 14;
    sy4_r   <= PRD_W'(hy3_r) <<< 14;
    lh4_r   <= PRD_W'(left_s) * hw_e;
    rh4_r   <= PRD_W'(right_r) * hw_e;
    bh4_r   <= PRD_W'(bottom_s) * hw_e;
    th4_r   <= PRD_W'(top_r) * hw_e;
  end

  // stage 5: edge compares
  logic             v5_r;
  div_tag_t         tag5_r;
  logic [DEN_W-1:0] magx5_r;
  logic [DEN_W-1:0] magy5_r;
  logic [DEN_W-1:0] den5_r;

  always_ff @(posedge clk) begin
    tag5_r.meta <= meta4_r;
    tag5_r.wz   <= wz4_r;
    tag5_r.sel  <= !wz4_r && (sx4_r > lh4_r) && (sx4_r < rh4_r)
                          && (sy4_r > bh4_r) && (sy4_r < th4_r);
    tag5_r.negx <= negx4_r;
    tag5_r.negy <= negy4_r;
    tag5_r.satx <= satx4_r;
    tag5_r.saty <= saty4_r;
    magx5_r     <= magx4_r;
    magy5_r     <= magy4_r;
    den5_r      <= den4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= xf_v;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // divide
  logic          dv_v;
  div_tag_t      dv_tag;
  logic [QB-1:0] dv_qx;
  logic [QB-1:0] dv_qy;

  vprs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (v5_r),
    .in_tag  (tag5_r),
    .in_magx (magx5_r),
    .in_magy (magy5_r),
    .in_den  (den5_r),
    .out_v   (dv_v),
    .out_tag (dv_tag),
    .out_qx  (dv_qx),
    .out_qy  (dv_qy)
  );

  // output register
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [15:0] px_nxt;
  logic [15:0] py_nxt;

  always_comb begin
    if (dv_tag.wz) begin
      px_nxt = '0;
    end else if (dv_tag.satx) begin
      px_nxt = dv_tag.negx ? 16'h8000 : 16'h7fff;
    end else begin
      px_nxt = dv_tag.negx ? -{1'b0, dv_qx} : {1'b0, dv_qx};
    end
    if (dv_tag.wz) begin
      py_nxt = '0;
    end else if (dv_tag.saty) begin
      py_nxt = dv_tag.negy ? 16'h8000 : 16'h7fff;
    end else begin
      py_nxt = dv_tag.negy ? -{1'b0, dv_qy} : {1'b0, dv_qy};
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.result_index <= dv_tag.meta.index;
    out_data_r.selected     <= dv_tag.sel;
    out_data_r.proj_x       <= px_nxt;
    out_data_r.proj_y       <= py_nxt;
    out_data_r.w_zero       <= dv_tag.wz;
    out_data_r.result_last  <= dv_tag.meta.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_wz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.w_zero |->
      !out_data.selected && out_data.proj_x == '0 && out_data.proj_y == '0)
    else $error("w zero result not cleared");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without matching transaction");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ##(QB + 1) out_valid)
    else $error("divider dropped a transaction");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertices through the projection and rectangle select block under
// several matrix and box settings, predicts each result and compares it.
// ----------------------------------------------------------------------------
module testbench;
  import vprs_pkg::*;

  localparam int LIMIT = 400000;

  class select_scoreboard;
    out_item_t pending[$];
    int errors;
    int seen;
    logic [63:0] rows[4];
    logic signed [15:0] bl, bb, bw, bh;

    function automatic logic signed [15:0] sat_div(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag * 16384) / den;
      if (num < 0) begin
        if (q > 32768) q = 32768;
        return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return 16'(q);
    endfunction

    function automatic longint row_sum(input logic [63:0] row, input longint v[4]);
      longint acc;
      logic signed [15:0] cf;
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        cf = row[16*c +: 16];
        acc += longint'(cf) * v[c];
      end
      return acc;
    endfunction

    function void note_vertex(input in_item_t it);
      longint v[4];
      longint hx, hy, hw, l, b, r, t;
      out_item_t e;
      v[0] = longint'(it.coord_x);
      v[1] = longint'(it.coord_y);
      v[2] = longint'(it.coord_z);
      v[3] = 256;
      hx = row_sum(rows[0], v);
      hy = row_sum(rows[1], v);
      hw = row_sum(rows[3], v);
      e = '0;
      e.result_index = it.vertex_index;
      e.result_last = it.last_vertex;
      if (hw == 0) begin
        e.w_zero = 1'b1;
      end else begin
        if (hw < 0) begin
          hx = -hx; hy = -hy; hw = -hw;
        end
        e.proj_x = sat_div(hx, hw);
        e.proj_y = sat_div(hy, hw);
        l = longint'(bl); b = longint'(bb);
        r = l + longint'(bw); t = b + longint'(bh);
        e.selected = (hx * 16384 > l * hw) && (hx * 16384 < r * hw) &&
                     (hy * 16384 > b * hw) && (hy * 16384 < t * hw);
      end
      pending.insert(pending.size(), e);
    endfunction

    task report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(input out_item_t r);
      out_item_t e;
      seen++;
      if (pending.size() == 0) begin
        report("unexpected transaction", longint'(r), 0);
        return;
      end
      e = pending.pop_front();
      if (r.result_index !== e.result_index)
        report("result_index", longint'(r.result_index), longint'(e.result_index));
      if (r.selected !== e.selected)
        report("selected", longint'(r.selected), longint'(e.selected));
      if (r.proj_x !== e.proj_x)
        report("proj_x", longint'(r.proj_x), longint'(e.proj_x));
      if (r.proj_y !== e.proj_y)
        report("proj_y", longint'(r.proj_y), longint'(e.proj_y));
      if (r.w_zero !== e.w_zero)
        report("w_zero", longint'(r.w_zero), longint'(e.w_zero));
      if (r.result_last !== e.result_last)
        report("result_last", longint'(r.result_last), longint'(e.result_last));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  select_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int phases = 0;
  bit calm = 0;

  always #2 clk = ~clk;

  vertex_project_rect_select dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_data);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("vertex_project_rect_select regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 6'(idx) << 3; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO, REG_ROW_THREE: sb.rows[idx] = val;
      REG_BOX_LEFT: sb.bl = val[15:0];
      REG_BOX_BOTTOM: sb.bb = val[15:0];
      REG_BOX_WIDTH: sb.bw = val[15:0];
      default: sb.bh = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_vertex(input in_item_t it);
    while (!calm && $urandom_range(99) < 11) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_vertex(it);
    sent++;
  endtask

  task automatic end_burst();
    start <= 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pack_row(input logic [15:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  function automatic in_item_t rand_vertex(input bit narrow);
    in_item_t it;
    it.vertex_index = 16'($urandom);
    it.last_vertex = 1'($urandom_range(1));
    if (narrow) begin
      it.coord_x = 16'($signed($urandom_range(1024)) - 512);
      it.coord_y = 16'($signed($urandom_range(1024)) - 512);
      it.coord_z = 16'($signed($urandom_range(1024)) - 512);
    end else begin
      it.coord_x = 16'($urandom);
      it.coord_y = 16'($urandom);
      it.coord_z = 16'($urandom);
    end
    return it;
  endfunction

  task automatic setting(input int kind);
    case (kind)
      0: begin
        write_reg(REG_ROW_ZERO, pack_row(16'h1000, 16'h0000, 16'h0000, 16'h0000));
        write_reg(REG_ROW_ONE, pack_row(16'h0000, 16'h1000, 16'h0000, 16'h0000));
        write_reg(REG_ROW_TWO, pack_row(16'h0000, 16'h0000, 16'h1000, 16'h0000));
        write_reg(REG_ROW_THREE, pack_row(16'h0000, 16'h0000, 16'h0000, 16'h1000));
        write_reg(REG_BOX_LEFT, 64'hC000);
        write_reg(REG_BOX_BOTTOM, 64'hC000);
        write_reg(REG_BOX_WIDTH, 64'h7FFF);
        write_reg(REG_BOX_HEIGHT, 64'h7FFF);
      end
      1: begin
        write_reg(REG_ROW_ZERO, 64'h8000_7FFF_8000_7FFF);
        write_reg(REG_ROW_ONE, 64'h7FFF_8000_7FFF_8000);
        write_reg(REG_ROW_TWO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_ROW_THREE, 64'h8000_8000_8000_8000);
        write_reg(REG_BOX_LEFT, 64'h8000);
        write_reg(REG_BOX_BOTTOM, 64'h7FFF);
        write_reg(REG_BOX_WIDTH, 64'h8000);
        write_reg(REG_BOX_HEIGHT, 64'h0000);
      end
      2: begin
        write_reg(REG_ROW_THREE, pack_row(16'h0100, 16'hFF00, 16'h0080, 16'h0000));
        write_reg(REG_BOX_LEFT, 64'h8000);
        write_reg(REG_BOX_BOTTOM, 64'h8000);
        write_reg(REG_BOX_WIDTH, 64'h7FFF);
        write_reg(REG_BOX_HEIGHT, 64'h7FFF);
      end
      default: begin
        write_reg(REG_ROW_ZERO, {$urandom, $urandom});
        write_reg(REG_ROW_ONE, {$urandom, $urandom});
        write_reg(REG_ROW_TWO, {$urandom, $urandom});
        write_reg(REG_ROW_THREE,
                  pack_row(16'($urandom_range(16'h0FFF)), 16'($urandom_range(16'h0FFF)),
                           16'($urandom_range(16'h0FFF)),
                           16'(16'h1000 + $urandom_range(16'h3FFF))));
        write_reg(REG_BOX_LEFT, 64'(16'(-$signed($urandom_range(16384)))));
        write_reg(REG_BOX_BOTTOM, 64'(16'(-$signed($urandom_range(16384)))));
        write_reg(REG_BOX_WIDTH, 64'(16'($urandom_range(32767))));
        write_reg(REG_BOX_HEIGHT, 64'($urandom));
      end
    endcase
    phases++;
  endtask

  initial begin
    in_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset matrix: w is zero everywhere
    it = '0; send_vertex(it);
    it = '{16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1}; send_vertex(it);
    end_burst();
    drain();

    setting(0);
    it = '{16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0}; send_vertex(it);
    it = '{16'd1, 16'h0080, 16'hFF80, 16'h1234, 1'b0}; send_vertex(it);
    it = '{16'd2, 16'h7FFF, 16'h8000, 16'h0000, 1'b0}; send_vertex(it);
    it = '{16'd3, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0}; send_vertex(it);
    it = '{16'd4, 16'hFFC0, 16'hFFC0, 16'h0000, 1'b0}; send_vertex(it);
    it = '{16'hFFFF, 16'h0040, 16'h0040, 16'h7FFF, 1'b1}; send_vertex(it);
    end_burst();
    drain();

    setting(1);
    it = '{16'd10, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}; send_vertex(it);
    it = '{16'd11, 16'h8000, 16'h8000, 16'h8000, 1'b0}; send_vertex(it);
    it = '{16'd12, 16'h0001, 16'hFFFF, 16'h0000, 1'b1}; send_vertex(it);
    end_burst();
    drain();

    // negative and zero w over a box from -32768 to -1 in x and y
    setting(2);
    it = '{16'd20, 16'h0000, 16'h0000, 16'h0000, 1'b0}; send_vertex(it);
    it = '{16'd21, 16'h0100, 16'h0000, 16'h0000, 1'b0}; send_vertex(it);
    it = '{16'd22, 16'h0000, 16'h0100, 16'h0000, 1'b0}; send_vertex(it);
    it = '{16'd23, 16'hFF00, 16'hFF00, 16'h0200, 1'b1}; send_vertex(it);
    for (int i = 0; i < 200; i++) send_vertex(rand_vertex(1'($urandom_range(1))));
    end_burst();
    drain();

    for (int p = 0; p < 5; p++) begin
      setting(3);
      calm = (p == 2);
      for (int i = 0; i < 200; i++) begin
        send_vertex(rand_vertex($urandom_range(3) != 0));
        if (i == 100) begin
          start <= 0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      calm = 0;
      end_burst();
      drain();
    end

    $display("covered %0d vertices across %0d register settings, %0d results checked",
             sent, phases, sb.seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("vertex_project_rect_select regression: pass");
    else
      $display("vertex_project_rect_select regression: fail");
    $finish;
  end
endmodule

[vertex_project_rect_select.f]
rtl/core/vprs_pkg.sv
rtl/core/vprs_xform.sv
rtl/core/vprs_div.sv
rtl/core/vertex_project_rect_select.sv
test/testbench.sv
